// ===== design/tmt_pkg.sv =====
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types, codes and byte classification for the markup tokenizer.
// ----------------------------------------------------------------------------
package tmt_pkg;

  // width of the position fields carried on the ports
  localparam int FieldWidth = 24;
  localparam int KindWidth = 5;
  localparam int CfgIndexWidth = 2;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegFirstLine = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegFirstColumn = 2'd1;

  // token kinds
  localparam logic [KindWidth-1:0] KindNewline = 5'd0;
  localparam logic [KindWidth-1:0] KindSpace = 5'd1;
  localparam logic [KindWidth-1:0] KindEof = 5'd2;
  localparam logic [KindWidth-1:0] KindLBrace = 5'd3;
  localparam logic [KindWidth-1:0] KindRBrace = 5'd4;
  localparam logic [KindWidth-1:0] KindLBracket = 5'd5;
  localparam logic [KindWidth-1:0] KindRBracket = 5'd6;
  localparam logic [KindWidth-1:0] KindLParen = 5'd7;
  localparam logic [KindWidth-1:0] KindRParen = 5'd8;
  localparam logic [KindWidth-1:0] KindDollar = 5'd9;
  localparam logic [KindWidth-1:0] KindAmp = 5'd10;
  localparam logic [KindWidth-1:0] KindUnderscore = 5'd11;
  localparam logic [KindWidth-1:0] KindCaret = 5'd12;
  localparam logic [KindWidth-1:0] KindTilde = 5'd13;
  localparam logic [KindWidth-1:0] KindPercent = 5'd14;
  localparam logic [KindWidth-1:0] KindRowBreak = 5'd15;
  localparam logic [KindWidth-1:0] KindCommand = 5'd16;
  localparam logic [KindWidth-1:0] KindIdent = 5'd17;
  localparam logic [KindWidth-1:0] KindProse = 5'd18;
  // returned by single_kind for bytes that are no one-byte markup token
  localparam logic [KindWidth-1:0] NotSingle = 5'd0;

  // special bytes
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharVt = 8'h0B;
  localparam logic [7:0] CharFf = 8'h0C;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharBackslash = 8'h5C;

  // result queue depth
  localparam int QueueDepth = 4;

  // one result item
  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [FieldWidth-1:0] offset;
    logic [FieldWidth-1:0] length;
    logic [FieldWidth-1:0] line;
    logic [FieldWidth-1:0] column;
    logic                  last;
  } tmt_token_t;

  // results of one step, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    tmt_token_t first;
    tmt_token_t second;
  } tmt_push_t;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_operator(input logic [7:0] b);
    is_operator = (b == "+") || (b == "-") || (b == "*") || (b == "/") ||
                  (b == "=") || (b == ",") || (b >= "0" && b <= "9");
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CharSpace) || (b >= CharTab && b <= CharCr);
  endfunction

  function automatic logic [KindWidth-1:0] single_kind(input logic [7:0] b);
    case (b)
      "{": single_kind = KindLBrace;
      "}": single_kind = KindRBrace;
      "[": single_kind = KindLBracket;
      "]": single_kind = KindRBracket;
      "(": single_kind = KindLParen;
      ")": single_kind = KindRParen;
      "$": single_kind = KindDollar;
      "&": single_kind = KindAmp;
      "_": single_kind = KindUnderscore;
      "^": single_kind = KindCaret;
      "~": single_kind = KindTilde;
      "%": single_kind = KindPercent;
      default: single_kind = NotSingle;
    endcase
  endfunction

  function automatic logic is_prose(input logic [7:0] b);
    is_prose = !is_blank(b) && (single_kind(b) == NotSingle) &&
               (b != CharBackslash) && !is_operator(b);
  endfunction

endpackage

// ===== design/tmt_byte_if.sv =====
// ----------------------------------------------------------------------------
// tmt_byte_if
// Source byte channel: valid/ready handshake with mode and data byte.
// ----------------------------------------------------------------------------
interface tmt_byte_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

// ===== design/tmt_token_if.sv =====
// ----------------------------------------------------------------------------
// tmt_token_if
// Token channel: valid/ready handshake with one token per item.
// ----------------------------------------------------------------------------
interface tmt_token_if;
  logic                           valid;
  logic                           ready;
  logic [tmt_pkg::KindWidth-1:0]  token_kind;
  logic [tmt_pkg::FieldWidth-1:0] token_offset;
  logic [tmt_pkg::FieldWidth-1:0] token_length;
  logic [tmt_pkg::FieldWidth-1:0] token_line;
  logic [tmt_pkg::FieldWidth-1:0] token_column;
  logic                           last_of_run;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output token_line, output token_column,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input token_line, input token_column,
                input last_of_run, output ready);
endinterface

// ===== design/tmt_core.sv =====
// ----------------------------------------------------------------------------
// tmt_core
// Lexer state and one-step token logic: classifies the held byte, closes
// the pending token if the byte cannot extend it, and opens or emits anew.
// ----------------------------------------------------------------------------
module tmt_core #(
  parameter int PositionWidth = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                mode,
  input  logic [7:0]                          data_byte,
  input  logic                                cfg_write,
  input  logic [tmt_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [tmt_pkg::FieldWidth-1:0]      cfg_data,
  output tmt_pkg::tmt_push_t                  push
);

  localparam int PW = PositionWidth;
  localparam int FW = tmt_pkg::FieldWidth;
  localparam int CW = 33;
  localparam logic [PW-1:0] PosMax = '1;

  typedef enum logic [2:0] {PNone, PCr, PWs, PBs, PCmd, PProse} pend_t;

  pend_t         pcls, pcls_next;
  logic [PW-1:0] token_start, start_next;
  logic [PW-1:0] byte_offset, offset_next;
  logic [PW-1:0] cur_line, line_next;
  logic [PW-1:0] cur_column, column_next;
  logic [PW-1:0] pend_line, pend_line_next;
  logic [PW-1:0] pend_column, pend_column_next;
  logic [FW-1:0] first_line;
  logic [FW-1:0] first_column;

  logic                      flush_v, fresh_v, done;
  tmt_pkg::tmt_token_t       flush_tok, fresh_tok, tok0, tok1;
  logic [1:0]                n_tok;
  logic [PW-1:0]             run_len;
  logic [tmt_pkg::KindWidth-1:0] skind;
  logic                      fresh_src;

  function automatic logic [PW-1:0] inc_sat(input logic [PW-1:0] v);
    inc_sat = (v == PosMax) ? PosMax : v + 1'b1;
  endfunction

  function automatic logic [PW-1:0] clamp_pos(input logic [FW-1:0] v);
    clamp_pos = (CW'(v) > CW'(PosMax)) ? PosMax : PW'(v);
  endfunction

  function automatic tmt_pkg::tmt_token_t make_tok(
    input logic [tmt_pkg::KindWidth-1:0] k, input logic [PW-1:0] off,
    input logic [PW-1:0] len, input logic [PW-1:0] ln, input logic [PW-1:0] col);
    tmt_pkg::tmt_token_t t;
    t.kind = k;
    t.offset = FW'(off);
    t.length = FW'(len);
    t.line = FW'(ln);
    t.column = FW'(col);
    t.last = 1'b0;
    make_tok = t;
  endfunction

  assign run_len = byte_offset - token_start;
  assign skind = tmt_pkg::single_kind(data_byte);
  assign fresh_src = (byte_offset == '0) && (pcls == PNone);

  // extend or close the pending token, then handle a byte it did not take from a clean slate
  always_comb begin
    flush_v = 1'b0;
    flush_tok = '0;
    fresh_v = 1'b0;
    fresh_tok = '0;
    done = 1'b0;
    pcls_next = pcls;
    start_next = token_start;
    offset_next = byte_offset;
    line_next = cur_line;
    column_next = cur_column;
    pend_line_next = pend_line;
    pend_column_next = pend_column;
    if (mode) begin
      // end of source: flush, report eof, rearm for a new source
      case (pcls)
        PCr: begin
          flush_v = 1'b1;
          flush_tok = make_tok(tmt_pkg::KindNewline, token_start, PW'(1), pend_line,
                               pend_column);
        end
        PBs: begin
          flush_v = 1'b1;
          flush_tok = make_tok(tmt_pkg::KindCommand, token_start, PW'(1), pend_line,
                               pend_column);
        end
        PWs: begin
          flush_v = 1'b1;
          flush_tok = make_tok(tmt_pkg::KindSpace, token_start, run_len, pend_line,
                               pend_column);
        end
        PCmd: begin
          flush_v = 1'b1;
          flush_tok = make_tok(tmt_pkg::KindCommand, token_start, run_len, pend_line,
                               pend_column);
        end
        PProse: begin
          flush_v = 1'b1;
          flush_tok = make_tok(tmt_pkg::KindProse, token_start, run_len, pend_line,
                               pend_column);
        end
        default: ;
      endcase
      fresh_v = 1'b1;
      fresh_tok = make_tok(tmt_pkg::KindEof, byte_offset, PW'(0), cur_line, cur_column);
      pcls_next = PNone;
      start_next = '0;
      offset_next = '0;
      line_next = clamp_pos(first_line);
      column_next = clamp_pos(first_column);
      pend_line_next = '0;
      pend_column_next = '0;
    end else begin
      // try to extend the pending token
      case (pcls)
        PCr: begin
          flush_v = 1'b1;
          pcls_next = PNone;
          if (data_byte == tmt_pkg::CharLf) begin
            flush_tok = make_tok(tmt_pkg::KindNewline, token_start, PW'(2), pend_line,
                                 pend_column);
            offset_next = inc_sat(byte_offset);
            done = 1'b1;
          end else begin
            flush_tok = make_tok(tmt_pkg::KindNewline, token_start, PW'(1), pend_line,
                                 pend_column);
          end
        end
        PBs: begin
          if (tmt_pkg::is_letter(data_byte)) begin
            pcls_next = PCmd;
          end else begin
            flush_v = 1'b1;
            pcls_next = PNone;
            flush_tok = make_tok((data_byte == tmt_pkg::CharBackslash) ?
                                 tmt_pkg::KindRowBreak : tmt_pkg::KindCommand,
                                 token_start, PW'(2), pend_line, pend_column);
          end
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
          done = 1'b1;
        end
        PWs: begin
          if (data_byte == tmt_pkg::CharSpace || data_byte == tmt_pkg::CharTab) begin
            offset_next = inc_sat(byte_offset);
            column_next = inc_sat(cur_column);
            done = 1'b1;
          end else begin
            flush_v = 1'b1;
            pcls_next = PNone;
            flush_tok = make_tok(tmt_pkg::KindSpace, token_start, run_len, pend_line,
                                 pend_column);
          end
        end
        PCmd: begin
          if (tmt_pkg::is_letter(data_byte)) begin
            offset_next = inc_sat(byte_offset);
            column_next = inc_sat(cur_column);
            done = 1'b1;
          end else begin
            flush_v = 1'b1;
            pcls_next = PNone;
            flush_tok = make_tok(tmt_pkg::KindCommand, token_start, run_len, pend_line,
                                 pend_column);
          end
        end
        PProse: begin
          if (tmt_pkg::is_prose(data_byte)) begin
            offset_next = inc_sat(byte_offset);
            column_next = inc_sat(cur_column);
            done = 1'b1;
          end else begin
            flush_v = 1'b1;
            pcls_next = PNone;
            flush_tok = make_tok(tmt_pkg::KindProse, token_start, run_len, pend_line,
                                 pend_column);
          end
        end
        default: pcls_next = PNone;
      endcase

      // byte with nothing pending; the flush leaves offset, line and column alone
      if (!done) begin
        if (data_byte == tmt_pkg::CharLf) begin
          fresh_v = 1'b1;
          fresh_tok = make_tok(tmt_pkg::KindNewline, byte_offset, PW'(1), cur_line,
                               cur_column);
          offset_next = inc_sat(byte_offset);
          line_next = inc_sat(cur_line);
          column_next = PW'(1);
        end else if (data_byte == tmt_pkg::CharCr) begin
          pcls_next = PCr;
          start_next = byte_offset;
          pend_line_next = cur_line;
          pend_column_next = cur_column;
          offset_next = inc_sat(byte_offset);
          line_next = inc_sat(cur_line);
          column_next = PW'(1);
        end else if (data_byte == tmt_pkg::CharSpace || data_byte == tmt_pkg::CharTab) begin
          pcls_next = PWs;
          start_next = byte_offset;
          pend_line_next = cur_line;
          pend_column_next = cur_column;
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
        end else if (data_byte == tmt_pkg::CharVt || data_byte == tmt_pkg::CharFf) begin
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
        end else if (skind != tmt_pkg::NotSingle) begin
          fresh_v = 1'b1;
          fresh_tok = make_tok(skind, byte_offset, PW'(1), cur_line, cur_column);
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
        end else if (data_byte == tmt_pkg::CharBackslash) begin
          pcls_next = PBs;
          start_next = byte_offset;
          pend_line_next = cur_line;
          pend_column_next = cur_column;
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
        end else if (tmt_pkg::is_operator(data_byte)) begin
          fresh_v = 1'b1;
          fresh_tok = make_tok(tmt_pkg::KindIdent, byte_offset, PW'(1), cur_line,
                               cur_column);
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
        end else begin
          pcls_next = PProse;
          start_next = byte_offset;
          pend_line_next = cur_line;
          pend_column_next = cur_column;
          offset_next = inc_sat(byte_offset);
          column_next = inc_sat(cur_column);
        end
      end
    end
  end

  // order the results and mark the final one
  always_comb begin
    tok0 = flush_v ? flush_tok : fresh_tok;
    tok1 = fresh_tok;
    if (flush_v) begin
      n_tok = fresh_v ? 2'd2 : 2'd1;
      tok0.last = !fresh_v;
      tok1.last = 1'b1;
    end else begin
      n_tok = {1'b0, fresh_v};
      tok0.last = 1'b1;
      tok1.last = 1'b0;
    end
    push.count = step ? n_tok : 2'd0;
    push.first = tok0;
    push.second = tok1;
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_line <= FW'(1);
      first_column <= FW'(1);
      pcls <= PNone;
      token_start <= '0;
      byte_offset <= '0;
      cur_line <= PW'(1);
      cur_column <= PW'(1);
      pend_line <= '0;
      pend_column <= '0;
    end else begin
      if (step) begin
        pcls <= pcls_next;
        token_start <= start_next;
        byte_offset <= offset_next;
        cur_line <= line_next;
        cur_column <= column_next;
        pend_line <= pend_line_next;
        pend_column <= pend_column_next;
      end else if (cfg_write) begin
        // a fresh source picks up the new start position at once
        if (cfg_index == tmt_pkg::RegFirstLine && fresh_src) begin
          cur_line <= clamp_pos(cfg_data);
        end
        if (cfg_index == tmt_pkg::RegFirstColumn && fresh_src) begin
          cur_column <= clamp_pos(cfg_data);
        end
      end
      if (cfg_write && cfg_index == tmt_pkg::RegFirstLine) begin
        first_line <= cfg_data;
      end
      if (cfg_write && cfg_index == tmt_pkg::RegFirstColumn) begin
        first_column <= cfg_data;
      end
    end
  end

  // end of source always ends in an eof token
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (step && mode) |->
      ((push.count == 2'd1 && push.first.kind == tmt_pkg::KindEof) ||
       (push.count == 2'd2 && push.second.kind == tmt_pkg::KindEof)))
    else $error("end of source without eof token");

  // offset only grows within a source
  a_offset_grows: assert property (@(posedge clk) disable iff (rst)
    (step && !mode) |=> (byte_offset >= $past(byte_offset)))
    else $error("byte offset went backwards");

  // a new source starts with nothing pending at offset zero
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (step && mode) |=> (byte_offset == '0 && pcls == PNone))
    else $error("source not rearmed after end marker");

endmodule

// ===== design/tmt_result_queue.sv =====
// ----------------------------------------------------------------------------
// tmt_result_queue
// Small token queue: takes up to two tokens a cycle, hands out one per item.
// ----------------------------------------------------------------------------
module tmt_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  tmt_pkg::tmt_push_t  push,
  output logic                room,
  tmt_token_if.source         tokens
);

  localparam int Depth = tmt_pkg::QueueDepth;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tmt_pkg::tmt_token_t entries [Depth];
  logic [PtrW-1:0] head, tail;
  logic [CntW-1:0] count;
  logic            pop;

  assign pop = tokens.valid && tokens.ready;
  // room for the worst case of one step
  assign room = (count <= CntW'(Depth - 2));

  // output head
  assign tokens.valid = (count != '0);
  assign tokens.token_kind = entries[head].kind;
  assign tokens.token_offset = entries[head].offset;
  assign tokens.token_length = entries[head].length;
  assign tokens.token_line = entries[head].line;
  assign tokens.token_column = entries[head].column;
  assign tokens.last_of_run = entries[head].last;

  // token storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[tail + 1'b1] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      tail <= tail + PtrW'(push.count);
      if (pop) begin
        head <= head + 1'b1;
      end
      count <= count + CntW'(push.count) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= CntW'(Depth - 2)))
    else $error("tokens pushed without room");

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue level out of range");

endmodule

// ===== design/tex_markup_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tex_markup_tokenizer
// Streaming lexer for TeX-like markup with position-tracked tokens.
// ----------------------------------------------------------------------------
// One source byte (or the end marker) is taken per clock cycle while the
// input register can accept it. Each item lands in that register, is
// classified and merged with the pending token, and its zero, one or two
// tokens are written into a four-entry result queue that offers them.
// Input is accepted whenever the input register is empty or is being
// drained, and draining needs room for two tokens in the queue, so the
// sustained rate is one item per cycle as long as items give one token or
// fewer on average and the sink takes one token per cycle. The end marker
// flushes the pending token, emits end-of-file and rearms offset, line and
// column from first_line and first_column (index 0 and 1 on the write
// port); write these only while the block is idle.
module tex_markup_tokenizer #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tmt_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tmt_pkg::FieldWidth-1:0]    cfg_data,
  tmt_byte_if.sink                          bytes,
  tmt_token_if.source                       tokens
);

  logic               held_valid;
  logic               held_mode;
  logic [7:0]         held_byte;
  logic               room;
  logic               step;
  tmt_pkg::tmt_push_t push;

  assign step = held_valid && room;
  assign bytes.ready = !held_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      held_mode <= bytes.mode;
      held_byte <= bytes.data_byte;
    end
  end

  tmt_core #(
    .PositionWidth(POSITION_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .mode      (held_mode),
    .data_byte (held_byte),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  tmt_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready) |=> held_valid)
    else $error("accepted item not held");

endmodule
